### hw/rtl/json_string_escaper_utf8_defines.svh
// Assertion macros shared by the escaper RTL.
`ifndef JSON_STRING_ESCAPER_UTF8_DEFINES_SVH
`define JSON_STRING_ESCAPER_UTF8_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/jse_pkg.sv
// Shared constants and types of the JSON string escaper.
`default_nettype none

package jse_pkg;

    localparam int MaxBuffer = 2048;
    localparam int SizeW     = 12;
    localparam int WcW       = $clog2(MaxBuffer);
    localparam int CmpW      = ((SizeW > WcW + 1) ? SizeW : WcW + 1) + 1;

    localparam int MaxRes    = 6;
    localparam int CntW      = $clog2(MaxRes + 1);
    localparam int IdxW      = $clog2(MaxRes);

    localparam int QDepth    = 2;
    localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW     = $clog2(QDepth + 1);

    localparam int ContN     = 3;
    localparam int ContIdxW  = $clog2(ContN);

    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChQmark     = 8'h3F;
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChDel       = 8'h7F;
    localparam logic [7:0] ChNul       = 8'h00;
    localparam int         Margin      = 5;

    // Register byte-address index (paddr[2])
    localparam logic RegOutSize = 1'b0;

    // Output bytes produced by one request, lowest slot first
    typedef struct packed {
        logic [MaxRes-1:0][7:0] bytes;
        logic [CntW-1:0]        cnt;
        logic                   term;
    } t_bundle;

endpackage

`default_nettype wire

### hw/rtl/json_string_escaper_utf8.sv
// Top level of the JSON string escaper with UTF-8 validation.
// Takes one raw string byte per request and emits its JSON-escaped form, one byte per clock
// while m_axis_tready is high. The input side accepts a byte every cycle while the two-entry
// bundle queue has room, even while earlier bytes still drain; each input yields zero to six
// output bytes, and the output side drains one byte per cycle unless m_axis_tready is low. The
// output rate is set by the single-byte back end. New characters are dropped once the bytes
// written plus five reach out_size; a zero byte or tlast closes the string with a zero byte
// marked by m_axis_tlast. No clearing pass follows reset. out_size is at APB byte address 0.
`default_nettype none

module json_string_escaper_utf8
    import jse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [SizeW-1:0] r_out_size;
    logic             push, pop, full, empty;
    t_bundle          push_bun, head_bun;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegOutSize) ? {{(32 - SizeW){1'b0}}, r_out_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_size <= SizeW'(MaxBuffer);
        end else if (psel && penable && pwrite && pready && paddr[2] == RegOutSize) begin
            r_out_size <= pwdata[SizeW-1:0];
        end
    end

    jse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_size   (r_out_size),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_bun)
    );

    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bun),
        .i_pop   (pop),
        .o_data  (head_bun),
        .o_full  (full),
        .o_empty (empty)
    );

    jse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (head_bun),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/jse_front.sv
// Front end: classifies each input byte, tracks UTF-8 and truncation state, builds output bundles.
`default_nettype none
`include "json_string_escaper_utf8_defines.svh"

module jse_front
    import jse_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    input  wire logic [SizeW-1:0] i_size,
    input  wire logic             i_full,
    output logic                  o_push,
    output t_bundle               o_bundle
);

    typedef struct packed {
        t_bundle        bun;
        logic [WcW-1:0] wc;
        logic           stopped;
    } t_work;

    logic [WcW-1:0]      r_wc,      n_wc;
    logic                r_stopped, n_stopped;
    logic [7:0]          r_lead,    n_lead;
    logic [1:0]          r_need,    n_need;
    logic [1:0]          r_held,    n_held;
    logic [ContN-1:0][7:0] r_cont,  n_cont;

    logic [CmpW-1:0] size_eff;
    logic            accept;
    logic            do_fresh;
    t_work           w;

    function automatic t_bundle f_add(t_bundle bun, logic [7:0] v);
        t_bundle r;
        r = bun;
        if (r.cnt < CntW'(MaxRes)) begin
            r.bytes[IdxW'(r.cnt)] = v;
            r.cnt = r.cnt + CntW'(1);
        end
        return r;
    endfunction

    function automatic t_work f_emit(t_work wi, logic [7:0] v);
        t_work r;
        r = wi;
        r.bun = f_add(r.bun, v);
        r.wc  = r.wc + WcW'(1);
        return r;
    endfunction

    function automatic logic f_fits(t_work wi, logic [CmpW-1:0] sz);
        return !wi.stopped && ((CmpW'(wi.wc) + CmpW'(Margin)) < sz);
    endfunction

    // A collected continuation handled fresh is always a stray byte.
    function automatic t_work f_stray(t_work wi, logic [CmpW-1:0] sz);
        t_work r;
        r = wi;
        if (f_fits(r, sz)) begin
            r = f_emit(r, ChQmark);
        end else begin
            r.stopped = 1'b1;
        end
        return r;
    endfunction

    function automatic t_work f_break(t_work wi, logic [1:0] held, logic [CmpW-1:0] sz);
        t_work r;
        r = f_emit(wi, ChQmark);
        for (int k = 0; k < ContN; k++) begin
            if (2'(k) < held) begin
                r = f_stray(r, sz);
            end
        end
        return r;
    endfunction

    // Sizes 0 and 1 behave alike, so only the upper clamp matters.
    assign size_eff = (CmpW'(i_size) > CmpW'(MaxBuffer)) ? CmpW'(MaxBuffer) : CmpW'(i_size);

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        w.bun     = '0;
        w.wc      = r_wc;
        w.stopped = r_stopped;
        n_lead    = r_lead;
        n_need    = r_need;
        n_held    = r_held;
        n_cont    = r_cont;
        do_fresh  = 1'b0;

        if (i_byte != ChNul) begin
            if (n_need != 2'd0 && i_byte[7:6] == 2'b10 && n_held < 2'd3) begin
                n_cont[ContIdxW'(n_held)] = i_byte;
                n_held = n_held + 2'd1;
                if (n_held >= n_need) begin
                    w = f_emit(w, n_lead);
                    for (int k = 0; k < ContN; k++) begin
                        if (2'(k) < n_held) begin
                            w = f_emit(w, n_cont[k]);
                        end
                    end
                    n_need = 2'd0;
                    n_held = 2'd0;
                end
            end else begin
                if (n_need != 2'd0) begin
                    w = f_break(w, n_held, size_eff);
                    n_need = 2'd0;
                    n_held = 2'd0;
                end
                do_fresh = 1'b1;
            end
        end

        if (do_fresh) begin
            if (!f_fits(w, size_eff)) begin
                w.stopped = 1'b1;
            end else if (i_byte == ChQuote || i_byte == ChBackslash) begin
                w = f_emit(w, ChBackslash);
                w = f_emit(w, i_byte);
            end else if (i_byte < ChSpace || i_byte == ChDel) begin
                w = f_emit(w, ChQmark);
            end else if (!i_byte[7]) begin
                w = f_emit(w, i_byte);
            end else if (i_byte[7:5] == 3'b110) begin
                n_lead = i_byte;
                n_need = 2'd1;
                n_held = 2'd0;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_lead = i_byte;
                n_need = 2'd2;
                n_held = 2'd0;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_lead = i_byte;
                n_need = 2'd3;
                n_held = 2'd0;
            end else begin
                w = f_emit(w, ChQmark);
            end
        end

        if (i_byte == ChNul || i_last) begin
            if (n_need != 2'd0) begin
                w = f_break(w, n_held, size_eff);
            end
            w.bun      = f_add(w.bun, ChNul);
            w.bun.term = 1'b1;
            w.wc       = '0;
            w.stopped  = 1'b0;
            n_lead     = 8'h00;
            n_need     = 2'd0;
            n_held     = 2'd0;
        end

        n_wc      = w.wc;
        n_stopped = w.stopped;
    end

    assign o_push   = accept && (w.bun.cnt != '0);
    assign o_bundle = w.bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc      <= '0;
            r_stopped <= 1'b0;
            r_lead    <= 8'h00;
            r_need    <= 2'd0;
            r_held    <= 2'd0;
        end else if (accept) begin
            r_wc      <= n_wc;
            r_stopped <= n_stopped;
            r_lead    <= n_lead;
            r_need    <= n_need;
            r_held    <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cont <= n_cont;
        end
    end

    `JSE_ASSERT_NOW(a_held_below_need, r_need != 2'd0, r_held < r_need, "held exceeds needed")
    `JSE_ASSERT_NOW(a_idle_no_held, r_need == 2'd0, r_held == 2'd0, "held without lead")

endmodule

`default_nettype wire

### hw/rtl/jse_queue.sv
// Bundle queue between the front and back ends.
`default_nettype none
`include "json_string_escaper_utf8_defines.svh"

module jse_queue
    import jse_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_data,
    input  wire logic    i_pop,
    output t_bundle      o_data,
    output logic         o_full,
    output logic         o_empty
);

    t_bundle              r_mem [QDepth];
    logic [QPtrW-1:0]     r_wr, r_rd;
    logic [QCntW-1:0]     r_count;
    logic                 push_ok, pop_ok;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == QPtrW'(QDepth - 1)) ? '0 : r_wr + QPtrW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == QPtrW'(QDepth - 1)) ? '0 : r_rd + QPtrW'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + QCntW'(1);
                2'b01:   r_count <= r_count - QCntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `JSE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= QCntW'(QDepth), "queue count overflow")
    `JSE_ASSERT_NOW(a_no_pop_empty, i_pop, !o_empty, "pop from empty queue")

endmodule

`default_nettype wire

### hw/rtl/jse_back.sv
// Back end: streams the bytes of each queued bundle out one per cycle while i_ready is high.
`default_nettype none
`include "json_string_escaper_utf8_defines.svh"

module jse_back
    import jse_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_bundle i_bundle,
    input  wire logic    i_empty,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_ready,
    output logic [7:0]   o_byte,
    output logic         o_last
);

    t_bundle         r_bun;
    logic [IdxW-1:0] r_idx;
    logic            r_busy;
    logic            final_byte;
    logic            xfer;

    assign final_byte = (CntW'(r_idx) + CntW'(1)) == r_bun.cnt;
    assign xfer       = r_busy && i_ready;
    // Reload in the same cycle the last byte leaves, so bundles run back to back.
    assign o_pop      = !i_empty && (!r_busy || (xfer && final_byte));

    assign o_valid = r_busy;
    assign o_byte  = r_bun.bytes[r_idx];
    assign o_last  = r_bun.term && final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (xfer) begin
            if (final_byte) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + IdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bun <= i_bundle;
        end
    end

    `JSE_ASSERT_NOW(a_idx_in_range, r_busy, CntW'(r_idx) < r_bun.cnt, "index past bundle")

endmodule

`default_nettype wire
